[sv/mnee_pkg.sv]
// shared types and constants of the midi note event encoder
// no dependencies; imported by the top level, front, queue and back
`default_nettype none

package mnee_pkg;

  // port widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 3;

  // track bytes
  localparam logic [7:0] BYTE_ZERO         = 8'h00;
  localparam logic [7:0] STATUS_NOTE_ON    = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF   = 8'h80;
  localparam logic [7:0] STATUS_META       = 8'hff;
  localparam logic [7:0] META_END_OF_TRACK = 8'h2f;

  localparam logic [7:0]  DATA_MAX  = 8'd127;
  localparam logic [30:0] VLQ_LIMIT = 31'h0fff_ffff;

  // track length bookkeeping
  localparam logic [31:0] END_EVENT_SIZE = 32'd4;
  // seven fixed bytes of a note plus the shortest quantity
  localparam logic [3:0]  NOTE_MIN_BYTES = 4'd8;

  // byte positions inside one event
  localparam logic [3:0] STEP_DELTA  = 4'd0;
  localparam logic [3:0] STEP_STATUS = 4'd1;
  localparam logic [3:0] STEP_DATA1  = 4'd2;
  localparam logic [3:0] STEP_DATA2  = 4'd3;
  localparam logic [3:0] STEP_VLQ    = 4'd4;

  // positions in the note-off tail
  localparam logic [3:0] TAIL_STATUS = 4'd0;
  localparam logic [3:0] TAIL_KEY    = 4'd1;
  localparam logic [3:0] TAIL_LAST   = 4'd2;

  typedef enum logic {
    OP_NOTE   = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    logic dur_long;
    logic vel_high;
    logic note_high;
  } flags_t;

  // one classified event handed from the front to the back
  typedef struct packed {
    op_e         op;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [27:0] vlq_groups;  // four 7-bit groups, least significant first
    logic [1:0]  vlq_last;    // quantity length minus one
    flags_t      flags;
    logic [31:0] len;
  } evt_t;

endpackage

`default_nettype wire

[sv/midi_note_event_encoder.sv]
// top level of the midi note event encoder: front, event queue and byte sequencer
// depends on mnee_pkg, mnee_front, mnee_queue and mnee_back
`default_nettype none

// Turns note events into MIDI track bytes, one byte per output beat. A note
// beat yields 00 90 note velocity, the duration as a big-endian variable-length
// quantity of one to four bytes, then 80 note 00: eight to eleven output beats.
// A finish beat yields 00 ff 2f 00 (four beats) and returns the track length to
// four. Every output beat carries the track length after its event, saturating
// at 32 bits, and the range flags of that event (zero on finish); tlast marks an
// event's final byte. The front accepts an input beat in any cycle that the
// event queue has room, so input beats may come back to back; the sustained
// rate is set by the back end, which emits one byte per cycle on the output
// port while the output is not stalled. From input acceptance to the first
// output beat, an event passes through the event queue and then the output
// register.

module midi_note_event_encoder
  import mnee_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2  // events held between front and back, 2 to 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // input beats
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata_i,   // note_number, note_velocity,
                                                  // note_duration (31), zero pad
  input  wire  [0:0]            s_axis_tuser_i,   // operation
  // output beats
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // out_byte, track_length (32)
  output logic                  m_axis_tlast_o,   // last_byte
  output logic [OUT_USER_W-1:0] m_axis_tuser_o    // note_too_high, velocity_too_high,
                                                  // duration_too_long
);

  evt_t   push_evt, head_evt;
  logic   push, pop, full, empty;
  logic [7:0]  out_byte;
  logic [31:0] out_len;
  flags_t out_flags;

  // classify and size each event, keep the running length
  mnee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (op_e'(s_axis_tuser_i[0])),
    .note_i     (s_axis_tdata_i[7:0]),
    .vel_i      (s_axis_tdata_i[15:8]),
    .dur_i      (s_axis_tdata_i[46:16]),
    .full_i     (full),
    .push_o     (push),
    .evt_o      (push_evt)
  );

  // decouples input acceptance from byte emission
  mnee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_evt),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_evt)
  );

  // one byte per beat from the head event, registered output
  mnee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (head_evt),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .byte_o      (out_byte),
    .last_o      (m_axis_tlast_o),
    .flags_o     (out_flags),
    .len_o       (out_len)
  );

  assign m_axis_tdata_o = {out_len, out_byte};
  assign m_axis_tuser_o = {out_flags.dur_long, out_flags.vel_high, out_flags.note_high};

endmodule

`default_nettype wire

[sv/mnee_front.sv]
// front end: accepts input beats, checks ranges, sizes the quantity
// and keeps the running track length; uses mnee_pkg
`default_nettype none

module mnee_front
  import mnee_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  op_e         in_op_i,
  input  wire  [7:0]  note_i,
  input  wire  [7:0]  vel_i,
  input  wire  [30:0] dur_i,
  input  wire         full_i,
  output logic        push_o,
  output evt_t        evt_o
);

  logic [31:0] count_q, count_d;
  logic        dur_long;
  logic [1:0]  vlq_last;
  logic [32:0] sum;
  logic [31:0] sat_len;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    dur_long = dur_i > VLQ_LIMIT;
    if (dur_long) begin
      vlq_last = 2'd0;
    end else if (dur_i[27:21] != 7'd0) begin
      vlq_last = 2'd3;
    end else if (dur_i[20:14] != 7'd0) begin
      vlq_last = 2'd2;
    end else if (dur_i[13:7] != 7'd0) begin
      vlq_last = 2'd1;
    end else begin
      vlq_last = 2'd0;
    end
    sum     = {1'b0, count_q} + 33'(NOTE_MIN_BYTES) + 33'(vlq_last);
    sat_len = sum[32] ? 32'hffff_ffff : sum[31:0];
  end

  always_comb begin
    evt_o.op         = in_op_i;
    evt_o.note       = note_i;
    evt_o.vel        = vel_i;
    evt_o.vlq_groups = dur_long ? 28'd0 : dur_i[27:0];
    evt_o.vlq_last   = vlq_last;
    count_d          = count_q;
    if (in_op_i == OP_FINISH) begin
      evt_o.flags = '0;
      evt_o.len   = count_q;
      if (push_o) begin
        count_d = END_EVENT_SIZE;
      end
    end else begin
      evt_o.flags.note_high = note_i > DATA_MAX;
      evt_o.flags.vel_high  = vel_i > DATA_MAX;
      evt_o.flags.dur_long  = dur_long;
      evt_o.len             = sat_len;
      if (push_o) begin
        count_d = sat_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= END_EVENT_SIZE;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

[sv/mnee_queue.sv]
// small event queue between front and back
// uses mnee_pkg for the event type
`default_nettype none

module mnee_queue
  import mnee_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  evt_t  data_i,
  output logic  full_o,
  input  wire   pop_i,
  output logic  empty_o,
  output evt_t  data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  evt_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/mnee_back.sv]
// back end: walks the head event one byte per beat into an output register
// uses mnee_pkg
`default_nettype none

module mnee_back
  import mnee_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  evt_t        evt_i,
  input  wire         empty_i,
  output logic        pop_o,
  input  wire         out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  byte_o,
  output logic        last_o,
  output flags_t      flags_o,
  output logic [31:0] len_o
);

  logic        valid_q;
  logic [3:0]  step_q, step_d;
  logic [7:0]  byte_q;
  logic        last_q;
  flags_t      flags_q;
  logic [31:0] len_q;

  logic        advance, take;
  logic [3:0]  rel, tail_idx;
  logic [1:0]  grp_idx;
  logic [6:0]  grp;
  logic [7:0]  next_byte;
  logic        next_last;

  assign advance = !valid_q || out_ready_i;
  assign take    = advance && !empty_i;
  assign pop_o   = take && next_last;

  always_comb begin
    rel      = step_q - STEP_VLQ;
    tail_idx = rel - {2'b00, evt_i.vlq_last} - 4'd1;
    grp_idx  = evt_i.vlq_last - rel[1:0];
    case (grp_idx)
      2'd0:    grp = evt_i.vlq_groups[6:0];
      2'd1:    grp = evt_i.vlq_groups[13:7];
      2'd2:    grp = evt_i.vlq_groups[20:14];
      default: grp = evt_i.vlq_groups[27:21];
    endcase

    next_byte = BYTE_ZERO;
    if (evt_i.op == OP_FINISH) begin
      // end of track: 00 ff 2f 00
      case (step_q)
        STEP_STATUS: next_byte = STATUS_META;
        STEP_DATA1:  next_byte = META_END_OF_TRACK;
        default:     next_byte = BYTE_ZERO;
      endcase
      next_last = step_q == STEP_DATA2;
    end else begin
      case (step_q)
        STEP_DELTA:  next_byte = BYTE_ZERO;
        STEP_STATUS: next_byte = STATUS_NOTE_ON;
        STEP_DATA1:  next_byte = evt_i.note;
        STEP_DATA2:  next_byte = evt_i.vel;
        default: begin
          if (rel <= {2'b00, evt_i.vlq_last}) begin
            // continuation bit on all but the final group
            next_byte = {rel[1:0] != evt_i.vlq_last, grp};
          end else begin
            case (tail_idx)
              TAIL_STATUS: next_byte = STATUS_NOTE_OFF;
              TAIL_KEY:    next_byte = evt_i.note;
              default:     next_byte = BYTE_ZERO;
            endcase
          end
        end
      endcase
      next_last = (step_q >= STEP_VLQ) && (tail_idx == TAIL_LAST);
    end

    step_d = step_q;
    if (take) begin
      step_d = next_last ? STEP_DELTA : step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= STEP_DELTA;
    end else begin
      if (advance) begin
        valid_q <= !empty_i;
      end
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q  <= next_byte;
      last_q  <= next_last;
      flags_q <= evt_i.flags;
      len_q   <= evt_i.len;
    end
  end

  assign out_valid_o = valid_q;
  assign byte_o      = byte_q;
  assign last_o      = last_q;
  assign flags_o     = flags_q;
  assign len_o       = len_q;

endmodule

`default_nettype wire

[sv/mnee_checker.sv]
// port-level checks on the output stream of the midi note event encoder
// bound to midi_note_event_encoder; no other dependencies
`default_nettype none

module mnee_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_tvalid_i,
  input wire        m_tready_i,
  input wire [39:0] m_tdata_i,
  input wire        m_tlast_i,
  input wire [2:0]  m_tuser_i
);

  // a stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i)
      && $stable(m_tlast_i) && $stable(m_tuser_i))
    else $error("output beat changed while stalled");

  // every event ends in a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tlast_i |-> m_tdata_i[7:0] == 8'h00)
    else $error("final byte of event is not zero");

  // the track length never drops below the end event size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[39:8] >= 32'd4)
    else $error("track length below end event size");

  // flags come only from notes, which grow the length by at least eight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i != 3'b000) |-> m_tdata_i[39:8] >= 32'd12)
    else $error("flagged beat with impossible track length");

endmodule

bind midi_note_event_encoder mnee_checker u_mnee_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o),
  .m_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
